FILE: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: operation and status
// codes, field widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic exec;
        logic load;
    } t_cmd;

endpackage

FILE: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit values in a DEPTH-entry ring buffer; push and pop
// at either end, one result beat per operation beat.
// ----------------------------------------------------------------------------
// An accepted operation beat registers the storage read; the result is then
//   loaded into the output register once that register is free. A new
//   operation beat is not taken until the previous result has been loaded.
// A finished result waits in the output register while the next beat is taken.
// Reset clears indices, count and handshake state; storage is not cleared.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] pop_value, [36:32] entry_count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    deq_pkg::t_cmd    cmd;
    deq_pkg::t_status status;
    logic signed [deq_pkg::VALUE_W-1:0] pop_value;
    logic [deq_pkg::COUNT_W-1:0]        entry_count;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (deq_pkg::t_op'(s_axis_tuser)),
        .i_push_value  (s_axis_tdata),
        .o_pop_value   (pop_value),
        .o_status      (status),
        .o_entry_count (entry_count)
    );

    assign m_axis_tdata = {3'b000, entry_count, pop_value};
    assign m_axis_tuser = status;

endmodule

FILE: src/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: takes one operation beat, registers the storage read, then
// moves the result into the output register when it is free.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output deq_pkg::t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.exec = i_in_valid && (r_state == S_IDLE);
        o_cmd.load = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);
        n_state    = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.exec) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (o_cmd.load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_exec_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_LOAD))
        else $error("exec did not move to load");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_out_valid)
        else $error("load did not raise output valid");
    a_no_exec_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.exec && o_cmd.load))
        else $error("exec and load in one cycle");
`endif

endmodule

FILE: src/deq_dpath.sv
// ----------------------------------------------------------------------------
// deq_dpath
// Ring-buffer storage with front and back indices and a fill count, plus
// the result register that faces the output stream.
// ----------------------------------------------------------------------------
module deq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  deq_pkg::t_cmd                    i_cmd,
    input  deq_pkg::t_op                     i_op,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_push_value,
    output logic signed [deq_pkg::VALUE_W-1:0] o_pop_value,
    output deq_pkg::t_status                 o_status,
    output logic [deq_pkg::COUNT_W-1:0]      o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [deq_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [deq_pkg::VALUE_W-1:0] r_rdata;

    logic [AW-1:0] r_front;
    logic [AW-1:0] n_front;
    logic [AW-1:0] r_back;
    logic [AW-1:0] n_back;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    deq_pkg::t_status r_pend_status;
    deq_pkg::t_status n_pend_status;
    logic             r_pend_pop;
    logic             n_pend_pop;

    logic signed [deq_pkg::VALUE_W-1:0] r_pop_value;
    deq_pkg::t_status                   r_status;
    logic [deq_pkg::COUNT_W-1:0]        r_entry_count;

    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] back_dec;
    logic [AW-1:0] back_inc;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          wen;
    logic          full;
    logic          empty;
    logic [CW+deq_pkg::COUNT_W-1:0] count_ext;

    always_comb begin
        front_dec = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
        front_inc = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
        back_dec  = (r_back == '0) ? LAST_IDX : r_back - AW'(1);
        back_inc  = (r_back == LAST_IDX) ? '0 : r_back + AW'(1);
        full      = (r_count == FULL_CNT);
        empty     = (r_count == '0);

        n_front       = r_front;
        n_back        = r_back;
        n_count       = r_count;
        n_pend_status = deq_pkg::ST_DONE;
        n_pend_pop    = 1'b0;
        waddr         = r_back;
        raddr         = r_front;
        wen           = 1'b0;

        unique case (i_op)
            deq_pkg::OP_PUSH_FRONT: begin
                waddr = front_dec;
                if (full) begin
                    n_pend_status = deq_pkg::ST_FULL;
                end else begin
                    wen     = 1'b1;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                waddr = r_back;
                if (full) begin
                    n_pend_status = deq_pkg::ST_FULL;
                end else begin
                    wen     = 1'b1;
                    n_back  = back_inc;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                raddr = r_front;
                if (empty) begin
                    n_pend_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_pend_pop = 1'b1;
                    n_front    = front_inc;
                    n_count    = r_count - CW'(1);
                end
            end
            deq_pkg::OP_POP_BACK: begin
                raddr = back_dec;
                if (empty) begin
                    n_pend_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_pend_pop = 1'b1;
                    n_back     = back_dec;
                    n_count    = r_count - CW'(1);
                end
            end
            default: n_pend_status = deq_pkg::ST_DONE;
        endcase

        count_ext = {{deq_pkg::COUNT_W{1'b0}}, r_count};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wen) begin
            r_mem[waddr] <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pend_status <= n_pend_status;
            r_pend_pop    <= n_pend_pop;
        end
        if (i_cmd.load) begin
            r_pop_value   <= r_pend_pop ? r_rdata : '0;
            r_status      <= r_pend_status;
            r_entry_count <= count_ext[deq_pkg::COUNT_W-1:0];
        end
    end

    assign o_pop_value   = r_pop_value;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count above depth");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && full && (i_op == deq_pkg::OP_PUSH_FRONT ||
         i_op == deq_pkg::OP_PUSH_BACK)) |=> $stable(r_count) && $stable(r_front))
        else $error("dropped push changed state");
    a_ends_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_CNT) |-> (r_front == r_back))
        else $error("indices disagree with fill count");
`endif

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_ended_queue. Operation beats go in on the
// slave stream with random gaps; result beats come out under random
// backpressure; some random-mix stretches have neither. A local ring-buffer
// model predicts the popped value, status and entry count of every accepted
// operation. Directed tests cover both ends, the empty and full cases and
// index wrap. A long random mix of fill, drain and balanced stretches follows.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int LATENCY    = 2;
    localparam int MAX_GAP    = 16;
    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_OPS = 1870;

    typedef struct {
        logic [deq_pkg::VALUE_W-1:0] value;
        deq_pkg::t_status            status;
        logic [deq_pkg::COUNT_W-1:0] count;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] push_value
    logic [1:0]  s_axis_tuser;   // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] pop_value, [36:32] entry_count
    logic [1:0]  m_axis_tuser;   // [1:0] status

    logic [deq_pkg::VALUE_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]            head_idx;
    logic [IDX_W-1:0]            tail_idx;
    logic [deq_pkg::COUNT_W-1:0] held;
    t_result                     expected_q[$];
    int                          err_count;
    int                          idle_cycles;
    bit                          no_idle;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic t_result apply_op(input deq_pkg::t_op op,
                                         input logic [deq_pkg::VALUE_W-1:0] value);
        t_result r;
        r.value  = '0;
        r.status = deq_pkg::ST_DONE;
        case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                if (held == DEPTH) begin
                    r.status = deq_pkg::ST_FULL;
                end else if (op == deq_pkg::OP_PUSH_FRONT) begin
                    head_idx       = head_idx - 1'b1;
                    ring[head_idx] = value;
                    held           = held + 1'b1;
                end else begin
                    ring[tail_idx] = value;
                    tail_idx       = tail_idx + 1'b1;
                    held           = held + 1'b1;
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = deq_pkg::ST_EMPTY;
                end else if (op == deq_pkg::OP_POP_FRONT) begin
                    r.value  = ring[head_idx];
                    head_idx = head_idx + 1'b1;
                    held     = held - 1'b1;
                end else begin
                    tail_idx = tail_idx - 1'b1;
                    r.value  = ring[tail_idx];
                    held     = held - 1'b1;
                end
            end
        endcase
        r.count = held;
        return r;
    endfunction

    function automatic logic [deq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(input deq_pkg::t_op op,
                           input logic [deq_pkg::VALUE_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(apply_op(op, value));
    endtask

    task automatic test_empty_pops();
        send_op(deq_pkg::OP_POP_FRONT, 32'hffff_ffff);
        send_op(deq_pkg::OP_POP_BACK, 32'h5555_aaaa);
    endtask

    task automatic test_both_ends();
        send_op(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_op(deq_pkg::OP_PUSH_BACK, 32'h7fff_ffff);
        send_op(deq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
        send_op(deq_pkg::OP_PUSH_BACK, 32'hffff_ffff);
        send_op(deq_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_op(deq_pkg::OP_POP_BACK, 32'hffff_ffff);
        send_op(deq_pkg::OP_POP_BACK, 32'h1234_5678);
        send_op(deq_pkg::OP_POP_FRONT, 32'h0000_0000);
    endtask

    task automatic test_fill_to_full();
        for (int i = 0; i < DEPTH; i++) begin
            send_op(i[0] ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT, pick_value());
        end
        send_op(deq_pkg::OP_PUSH_FRONT, pick_value());
        send_op(deq_pkg::OP_PUSH_BACK, pick_value());
    endtask

    task automatic test_random_mix();
        int           left;
        int           seg_len;
        int           push_pct;
        deq_pkg::t_op op;
        left = RANDOM_OPS;
        while (left > 0) begin
            seg_len = $urandom_range(20, 60);
            if (seg_len > left) begin
                seg_len = left;
            end
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                if ($urandom_range(1, 100) <= push_pct) begin
                    op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK
                                              : deq_pkg::OP_PUSH_FRONT;
                end else begin
                    op = $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK
                                              : deq_pkg::OP_POP_FRONT;
                end
                send_op(op, pick_value());
            end
            left -= seg_len;
        end
        no_idle = 1'b0;
    endtask

    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                note_error($sformatf("unexpected result beat: tdata %h tuser %h",
                                     m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata[31:0] !== want.value || m_axis_tuser !== want.status ||
                    m_axis_tdata[36:32] !== want.count) begin
                    note_error($sformatf(
                        "mismatch: value %h/%h status %0d/%0d count %0d/%0d (exp/act)",
                        want.value, m_axis_tdata[31:0], want.status, m_axis_tuser,
                        want.count, m_axis_tdata[36:32]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL double_ended_queue");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        head_idx      = '0;
        tail_idx      = '0;
        held          = '0;
        err_count     = 0;
        idle_cycles   = 0;
        no_idle       = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pops();
        test_both_ends();
        test_fill_to_full();
        test_random_mix();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("PASS double_ended_queue");
        end else begin
            $display("FAIL double_ended_queue");
        end
        $finish;
    end

endmodule
